### rtl/rbbp_pkg.sv
`timescale 1ns / 1ps

package rbbp_pkg;

  // fixed sizes of the handle fields and of the per-block table
  localparam int ADDR_W   = 32;
  localparam int IDX_W    = 5;
  localparam int GEN_W    = 8;
  localparam int CNT_W    = 8;
  localparam int FCNT_W   = 6;
  localparam int MAX_BLKS = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_ADDREF = 2'd2,
    ACT_INIT   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_STALE    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] handle_address;
    logic [IDX_W-1:0]  handle_index;
    logic [GEN_W-1:0]  handle_generation;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  block_index;
    logic [GEN_W-1:0]  block_generation;
    logic [ADDR_W-1:0] block_address;
    logic              released;
    logic [FCNT_W-1:0] free_count;
  } rsp_t;

endpackage

### rtl/refcounted_bitmap_block_pool.sv
`timescale 1ns / 1ps

// reference counted block pool with generation tags
//
// request channel: req is taken at a rising edge with start high and busy low;
// one request transfer gives exactly one result transfer
// result channel: rsp is valid for the single cycle in which done is high;
// the receiver cannot stall, so results are never held back or dropped
// config: cfg_we writes cfg_data into pool_base; write only while idle
//
// timing: busy is high only in the cycle after the transfer, done follows in the
// cycle after that, and the next request may be taken in that same cycle.
// the per-block table entry is read at the transfer and is modified and
// written back in the run cycle; no new request is taken while busy is high.
//
// reset: pool_base goes to 0, every block is free, counts and generations
// read as zero (per-entry valid bits are cleared at once, no clearing pass).
// reinitialize does the same in one step but keeps pool_base.
module refcounted_bitmap_block_pool #(
  parameter int BLOCK_COUNT = 32,
  parameter int BLOCK_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rbbp_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data,
  output logic          done,
  output rbbp_pkg::rsp_t rsp
);

  localparam int IW = rbbp_pkg::IDX_W;
  localparam int GW = rbbp_pkg::GEN_W;
  localparam int CW = rbbp_pkg::CNT_W;
  localparam int AW = rbbp_pkg::ADDR_W;
  localparam int FW = rbbp_pkg::FCNT_W;
  localparam int NB = rbbp_pkg::MAX_BLKS;

  // low BLOCK_COUNT bits set
  localparam logic [NB-1:0] ALL_FREE = NB'((64'd1 << BLOCK_COUNT) - 64'd1);
  localparam logic [FW-1:0] NBLK     = FW'(BLOCK_COUNT);

  // two-phase control: idle accepts, run does the read-modify-write
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  // configuration and pool state
  logic [AW-1:0] pool_base;
  logic [NB-1:0] free_map, free_map_next;
  logic [FW-1:0] free_cnt, free_cnt_next;
  logic [NB-1:0] ent_vld, ent_vld_next;

  // per-block table: {generation, count}
  logic [GW+CW-1:0] ent_mem [NB];
  logic [GW+CW-1:0] rd_data;
  logic             rd_vld;
  logic             mem_we;
  logic [GW+CW-1:0] mem_wdata;

  // request captured at the transfer
  rbbp_pkg::action_t act_q;
  logic [IW-1:0]     idx_q;
  logic [GW-1:0]     hgen_q;
  logic              hok_q;
  logic              full_q;

  // accept side
  logic          accept;
  logic [IW-1:0] alloc_idx;
  logic [IW-1:0] rd_idx;
  logic [AW:0]   exp_addr;
  logic          handle_ok;

  rbbp_pkg::rsp_t rsp_next;

  assign busy   = (state == S_RUN);
  assign accept = start && !busy;

  // highest free block wins
  always_comb begin
    alloc_idx = '0;
    for (int i = 0; i < NB; i++) begin
      if (free_map[i]) alloc_idx = IW'(i);
    end
  end

  // a handle is good when it is nonzero, its index is below BLOCK_COUNT and its
  // address starts its block; the sum is one bit wider so a wrap never matches
  assign exp_addr  = {1'b0, pool_base}
                   + (AW+1)'((AW+1)'(req.handle_index) * (AW+1)'(BLOCK_BYTES));
  assign handle_ok = (req.handle_address != '0)
                  && ((FW)'(req.handle_index) < NBLK)
                  && ({1'b0, req.handle_address} == exp_addr);

  assign rd_idx = (req.action == rbbp_pkg::ACT_ALLOC) ? alloc_idx : req.handle_index;

  // table memory: read at the transfer, written back in the run cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem[idx_q] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= ent_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= req.action;
      idx_q  <= rd_idx;
      hgen_q <= req.handle_generation;
      hok_q  <= handle_ok;
      full_q <= (free_map == '0);
      rd_vld <= ent_vld[rd_idx];
    end
  end

  // read-modify-write of one entry
  always_comb begin
    logic [GW-1:0] gen;
    logic [CW-1:0] cnt;
    logic          is_free;

    gen     = rd_vld ? rd_data[GW+CW-1:CW] : '0;
    cnt     = rd_vld ? rd_data[CW-1:0] : '0;
    is_free = free_map[idx_q];

    state_next    = state;
    free_map_next = free_map;
    free_cnt_next = free_cnt;
    ent_vld_next  = ent_vld;
    mem_we        = 1'b0;
    mem_wdata     = {gen, cnt};

    rsp_next                  = '0;
    rsp_next.status           = rbbp_pkg::ST_OK;

    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_RUN;
      end
      S_RUN: begin
        state_next = S_IDLE;
        unique case (act_q)
          rbbp_pkg::ACT_ALLOC: begin
            if (full_q) begin
              rsp_next.status = rbbp_pkg::ST_FULL;
            end else begin
              mem_we                    = 1'b1;
              mem_wdata                 = {GW'(gen + GW'(1)), CW'(1)};
              ent_vld_next[idx_q]       = 1'b1;
              free_map_next[idx_q]      = 1'b0;
              free_cnt_next             = free_cnt - FW'(1);
              rsp_next.block_index      = idx_q;
              rsp_next.block_generation = GW'(gen + GW'(1));
              rsp_next.block_address    = pool_base
                                        + AW'(AW'(idx_q) * AW'(BLOCK_BYTES));
            end
          end
          rbbp_pkg::ACT_FREE: begin
            priority if (!hok_q) begin
              rsp_next.status = rbbp_pkg::ST_INVALID;
            end else if (gen != hgen_q) begin
              rsp_next.status = rbbp_pkg::ST_STALE;
            end else if (is_free || cnt == '0) begin
              rsp_next.status = rbbp_pkg::ST_INVALID;
            end else begin
              mem_we              = 1'b1;
              mem_wdata           = {gen, CW'(cnt - CW'(1))};
              ent_vld_next[idx_q] = 1'b1;
              // last reference gone
              if (cnt == CW'(1)) begin
                free_map_next[idx_q] = 1'b1;
                free_cnt_next        = free_cnt + FW'(1);
                rsp_next.released    = 1'b1;
              end
            end
          end
          rbbp_pkg::ACT_ADDREF: begin
            priority if (!hok_q || is_free) begin
              rsp_next.status = rbbp_pkg::ST_INVALID;
            end else if (gen != hgen_q) begin
              rsp_next.status = rbbp_pkg::ST_STALE;
            end else if (cnt == rbbp_pkg::CNT_MAX) begin
              rsp_next.status = rbbp_pkg::ST_OVERFLOW;
            end else begin
              mem_we              = 1'b1;
              mem_wdata           = {gen, CW'(cnt + CW'(1))};
              ent_vld_next[idx_q] = 1'b1;
            end
          end
          rbbp_pkg::ACT_INIT: begin
            free_map_next = ALL_FREE;
            free_cnt_next = NBLK;
            ent_vld_next  = '0;
          end
          default: ;
        endcase
      end
      default: state_next = S_IDLE;
    endcase

    rsp_next.free_count = free_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pool_base <= '0;
      free_map  <= ALL_FREE;
      free_cnt  <= NBLK;
      ent_vld   <= '0;
      done      <= 1'b0;
    end else begin
      state    <= state_next;
      free_map <= free_map_next;
      free_cnt <= free_cnt_next;
      ent_vld  <= ent_vld_next;
      done     <= busy;
      if (cfg_we) pool_base <= cfg_data;
    end
  end

  // result register, loaded in the run cycle and valid while done is high
  always_ff @(posedge clk) begin
    if (busy) rsp <= rsp_next;
  end

endmodule

### rtl/rbbp_checker.sv
`timescale 1ns / 1ps

module rbbp_checker #(
  parameter int BLOCK_COUNT = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input rbbp_pkg::rsp_t rsp
);

  // a request transfer locks the port for its work cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request transfer");

  // every result follows a work cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a work cycle");

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.free_count <= 6'(BLOCK_COUNT))
    else $error("free count beyond pool size");

  // block fields only carry data on a good allocate
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != rbbp_pkg::ST_OK |->
      rsp.block_index == '0 && rsp.block_generation == '0 && rsp.block_address == '0)
    else $error("block fields set on a failed request");

  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.released |-> rsp.status == rbbp_pkg::ST_OK && rsp.block_address == '0)
    else $error("release flagged on a failed or non-free request");

endmodule

bind refcounted_bitmap_block_pool rbbp_checker #(.BLOCK_COUNT(BLOCK_COUNT)) u_rbbp_checker (.*);

### dv/pool_checker.sv
`timescale 1ns / 1ps

module pool_checker
  import rbbp_pkg::*;
#(
  parameter int BLOCK_COUNT = 32,
  parameter int BLOCK_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        req,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  rsp_t        rsp,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [MAX_BLKS-1:0] ALL_FREE = MAX_BLKS'((64'd1 << BLOCK_COUNT) - 64'd1);

  // shadow copy of the pool
  logic [31:0]         base;
  logic [MAX_BLKS-1:0] free_map;
  logic [CNT_W-1:0]    refs [MAX_BLKS];
  logic [GEN_W-1:0]    gens [MAX_BLKS];

  rsp_t owed_rsps [$];

  function automatic void clear_pool();
    free_map = ALL_FREE;
    for (int i = 0; i < MAX_BLKS; i++) begin
      refs[i] = '0;
      gens[i] = '0;
    end
  endfunction

  // address must be nonzero, in range, block aligned and agree with the index
  function automatic logic handle_slot(input req_t r, output logic [IDX_W-1:0] slot);
    logic [32:0] off;
    slot = '0;
    if (r.handle_address == '0 || r.handle_address < base) return 1'b0;
    off = {1'b0, r.handle_address} - {1'b0, base};
    if (off >= 33'(BLOCK_COUNT * BLOCK_BYTES)) return 1'b0;
    if (off % BLOCK_BYTES != 0) return 1'b0;
    if (off / BLOCK_BYTES != 33'(r.handle_index)) return 1'b0;
    slot = IDX_W'(off / BLOCK_BYTES);
    return 1'b1;
  endfunction

  function automatic rsp_t predict_pool_response(input req_t r);
    rsp_t             o;
    logic [IDX_W-1:0] slot;
    o = '0;
    o.status = ST_OK;
    slot = '0;
    case (r.action)
      ACT_ALLOC: begin
        if (free_map == '0) begin
          o.status = ST_FULL;
        end else begin
          // highest free index wins
          for (int i = 0; i < MAX_BLKS; i++) if (free_map[i]) slot = IDX_W'(i);
          free_map[slot] = 1'b0;
          refs[slot] = 8'd1;
          gens[slot] = gens[slot] + 8'd1;
          o.block_index = slot;
          o.block_generation = gens[slot];
          o.block_address = base + 32'(slot) * 32'(BLOCK_BYTES);
        end
      end
      ACT_FREE: begin
        if (!handle_slot(r, slot)) o.status = ST_INVALID;
        else if (gens[slot] != r.handle_generation) o.status = ST_STALE;
        else if (free_map[slot] || refs[slot] == '0) o.status = ST_INVALID;
        else begin
          refs[slot] = refs[slot] - 8'd1;
          if (refs[slot] == '0) begin
            free_map[slot] = 1'b1;
            o.released = 1'b1;
          end
        end
      end
      ACT_ADDREF: begin
        if (!handle_slot(r, slot)) o.status = ST_INVALID;
        else if (free_map[slot]) o.status = ST_INVALID;
        else if (gens[slot] != r.handle_generation) o.status = ST_STALE;
        else if (refs[slot] == CNT_MAX) o.status = ST_OVERFLOW;
        else refs[slot] = refs[slot] + 8'd1;
      end
      default: clear_pool();
    endcase
    o.free_count = FCNT_W'($countones(free_map));
    return o;
  endfunction

  always @(posedge clk) begin : watch_channels
    rsp_t want;
    if (rst) begin
      base = '0;
      clear_pool();
      owed_rsps.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) base = cfg_data;
      if (start && !busy) owed_rsps.push_back(predict_pool_response(req));
      if (done) begin
        if (owed_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing outstanding: %p", $realtime, rsp);
        end else begin
          want = owed_rsps.pop_front();
          if (rsp.status !== want.status || rsp.block_index !== want.block_index ||
              rsp.block_generation !== want.block_generation ||
              rsp.block_address !== want.block_address ||
              rsp.released !== want.released || rsp.free_count !== want.free_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected status %0d idx %0d gen %0d addr %h rel %0d free %0d",
                       $realtime, want.status, want.block_index, want.block_generation,
                       want.block_address, want.released, want.free_count);
              $display("%0t:           got status %0d idx %0d gen %0d addr %h rel %0d free %0d",
                       $realtime, rsp.status, rsp.block_index, rsp.block_generation,
                       rsp.block_address, rsp.released, rsp.free_count);
            end
          end
        end
      end
    end
    outstanding = owed_rsps.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rbbp_pkg::*;

  localparam int BLOCK_COUNT = 32;
  localparam int BLOCK_BYTES = 64;
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either channel
  localparam int PHASE_ITEMS = 235;
  localparam int HANDLE_KEEP = 48;    // recent handles kept for reuse

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        done;
  rsp_t        rsp;

  int mismatches;
  int outstanding;

  // stimulus-side bookkeeping
  logic [31:0] cur_base;
  bit          steady;          // no idle cycles on the request side
  req_t        handles [$];     // handles returned by successful allocs
  action_t     issued_q [$];    // action of every request transfer, in order
  int          n_by_action [4];
  int          n_by_status [5];
  int          n_released;
  int          quiet_cycles;

  refcounted_bitmap_block_pool #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .rsp(rsp)
  );

  pool_checker #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .rsp(rsp),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: any request or result transfer restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // harvest handles from alloc results so later free/add-ref requests can use them
  always @(posedge clk) begin : harvest
    action_t a;
    if (!rst && done && issued_q.size() != 0) begin
      a = issued_q.pop_front();
      if (rsp.status <= ST_OVERFLOW) n_by_status[rsp.status]++;
      if (rsp.released) n_released++;
      if (a == ACT_ALLOC && rsp.status == ST_OK) begin
        handles.push_back(make_req(ACT_FREE, rsp.block_address, rsp.block_index,
                                   rsp.block_generation));
        if (handles.size() > HANDLE_KEEP) void'(handles.pop_front());
      end
    end
  end

  function automatic req_t make_req(action_t a, logic [31:0] addr, logic [IDX_W-1:0] idx,
                                    logic [GEN_W-1:0] gen);
    req_t r;
    r.action = a;
    r.handle_address = addr;
    r.handle_index = idx;
    r.handle_generation = gen;
    return r;
  endfunction

  // mostly a real handle, sometimes damaged in one way so each check gets hit
  function automatic req_t handle_request(action_t a);
    req_t             h;
    int               r;
    int               span;
    logic [IDX_W-1:0] k;
    if (handles.size() == 0) begin
      k = IDX_W'($urandom_range(BLOCK_COUNT - 1));
      h = make_req(a, cur_base + 32'(k) * 32'(BLOCK_BYTES), k, GEN_W'($urandom_range(1, 3)));
    end else if ($urandom_range(1)) begin
      h = handles[$urandom_range(handles.size() - 1)];
    end else begin
      span = (handles.size() > 8) ? 7 : handles.size() - 1;
      h = handles[handles.size() - 1 - $urandom_range(span)];
    end
    h.action = a;
    r = $urandom_range(99);
    if (r < 8) begin
      h.handle_generation += GEN_W'($urandom_range(1, 255));
    end else if (r < 14) begin
      h.handle_index ^= IDX_W'($urandom_range(1, 31));
    end else if (r < 19) begin
      h.handle_address += 32'($urandom_range(1, BLOCK_BYTES - 1));
    end else if (r < 23) begin
      h.handle_address = '0;
    end else if (r < 27) begin
      // just below the pool or at/after its end
      if ($urandom_range(1))
        h.handle_address = cur_base - 32'($urandom_range(1, 4096));
      else
        h.handle_address = cur_base + 32'(BLOCK_COUNT * BLOCK_BYTES) +
                           32'($urandom_range(0, 4096));
    end else if (r < 30) begin
      h = make_req(a, $urandom, IDX_W'($urandom), GEN_W'($urandom));
    end
    return h;
  endfunction

  // one request transfer; returns at the falling edge after acceptance
  task automatic issue(input req_t r);
    while (!steady && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    issued_q.push_back(r.action);
    n_by_action[r.action]++;
    @(negedge clk);
  endtask

  // wait for every result still owed
  task automatic drain();
    start <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  // pool_base changes only with the block idle
  task automatic write_base(input logic [31:0] v);
    drain();
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_base = v;
  endtask

  task automatic random_run(input int count, input bit alloc_heavy);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < (alloc_heavy ? 60 : 32))
        issue(make_req(ACT_ALLOC, $urandom, IDX_W'($urandom), GEN_W'($urandom)));
      else if (r < (alloc_heavy ? 78 : 64))
        issue(handle_request(ACT_FREE));
      else if (r < 97)
        issue(handle_request(ACT_ADDREF));
      else if (r < 98)
        issue(make_req(ACT_INIT, $urandom, IDX_W'($urandom), GEN_W'($urandom)));
      else
        issue(make_req(action_t'($urandom_range(3)), $urandom, IDX_W'($urandom),
                       GEN_W'($urandom)));
    end
  endtask

  // push one block's count up into saturation, then free it all the way down
  task automatic saturate_one_block();
    req_t h;
    issue(make_req(ACT_INIT, '0, '0, '0));
    issue(make_req(ACT_ALLOC, '0, '0, '0));
    drain();
    h = handles[handles.size() - 1];
    h.action = ACT_ADDREF;
    for (int k = 0; k < 258; k++) issue(h);
    h.action = ACT_FREE;
    for (int k = 0; k < 257; k++) issue(h);
  endtask

  initial begin
    logic [31:0] base_sel [6];
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    cur_base = '0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // pool_base settings: zero (block 0 reads as null), all ones, pool ending
    // exactly at the top of the address space, block addresses that wrap,
    // a safe aligned base, and an arbitrary one
    base_sel[0] = 32'h0000_0000;
    base_sel[1] = 32'hFFFF_FFFF;
    base_sel[2] = 32'hFFFF_F800;
    base_sel[3] = 32'hFFFF_FFC0;
    base_sel[4] = {2'b00, 24'($urandom_range(1, 24'hFF_FFFF)), 6'b0};
    base_sel[5] = $urandom;

    write_base(base_sel[0]);

    // directed: every check order, extremes of the fields, base zero
    issue(make_req(ACT_FREE, '0, '0, '0));                       // null handle
    issue(make_req(ACT_ADDREF, '1, '1, '1));                     // all-ones handle
    issue(make_req(ACT_ALLOC, '1, '1, '1));                      // block 31, gen 1
    issue(make_req(ACT_ADDREF, 32'(31 * BLOCK_BYTES), 5'd31, 8'd1));
    issue(make_req(ACT_ADDREF, 32'(31 * BLOCK_BYTES), 5'd31, 8'd0));  // stale
    issue(make_req(ACT_FREE, 32'(31 * BLOCK_BYTES), 5'd31, 8'd2));    // stale
    issue(make_req(ACT_FREE, 32'(31 * BLOCK_BYTES), 5'd30, 8'd1));    // index disagrees
    issue(make_req(ACT_FREE, 32'(31 * BLOCK_BYTES) + 1, 5'd31, 8'd1)); // misaligned
    issue(make_req(ACT_FREE, 32'(32 * BLOCK_BYTES), 5'd0, 8'd1));     // past the end
    issue(make_req(ACT_FREE, 32'(31 * BLOCK_BYTES), 5'd31, 8'd1));    // count 2 -> 1
    issue(make_req(ACT_FREE, 32'(31 * BLOCK_BYTES), 5'd31, 8'd1));    // released
    issue(make_req(ACT_FREE, 32'(31 * BLOCK_BYTES), 5'd31, 8'd1));    // already free
    issue(make_req(ACT_ADDREF, 32'(31 * BLOCK_BYTES), 5'd31, 8'd1));  // free block
    issue(make_req(ACT_ALLOC, '0, '0, '0));                      // block 31, gen 2
    issue(make_req(ACT_ALLOC, '0, '0, '0));                      // block 30, gen 1
    issue(make_req(ACT_INIT, '1, '1, '1));                       // wipe pool
    issue(make_req(ACT_ALLOC, '0, '0, '0));                      // gen back to 1
    issue(make_req(ACT_FREE, 32'(31 * BLOCK_BYTES), 5'd31, 8'd1));
    random_run(PHASE_ITEMS, 1'b1);

    for (int p = 1; p < 6; p++) begin
      write_base(base_sel[p]);
      steady = (p == 2);
      random_run(PHASE_ITEMS, (p == 1 || p == 3));
      if (p == 4) saturate_one_block();
    end
    steady = 1'b0;

    drain();
    repeat (4) @(posedge clk);

    $display("covered %0d alloc, %0d free, %0d add-ref, %0d reinit transfers over 6 bases",
             n_by_action[ACT_ALLOC], n_by_action[ACT_FREE], n_by_action[ACT_ADDREF],
             n_by_action[ACT_INIT]);
    $display("status ok/full/invalid/stale/overflow %0d/%0d/%0d/%0d/%0d, %0d releases",
             n_by_status[ST_OK], n_by_status[ST_FULL], n_by_status[ST_INVALID],
             n_by_status[ST_STALE], n_by_status[ST_OVERFLOW], n_released);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, outstanding);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
